>>> rtl/lfu_pkg.sv
// Shared types and constants for the LFU cache engine.
`default_nettype none
package lfu_pkg;

   localparam int KEY_W = 32;
   localparam int VAL_W = 32;
   localparam int CNT_W = 32;
   localparam int TCH_W = 32;
   localparam int CAP_W = 5;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   typedef enum logic {
      CMD_GET = 1'b0,
      CMD_PUT = 1'b1
   } cmd_type;

   // one stored entry, as read from or written to the entry memories
   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value;
      logic [CNT_W-1:0] count;
      logic [TCH_W-1:0] touch;
   } entry_type;

   // what one scan over the entries has found
   typedef struct packed {
      logic found;
      logic victim;
      logic free;
   } scan_flags_type;

endpackage
`default_nettype wire

>>> rtl/lfu_entry_store.sv
// Entry memories with registered read port, one write port and per-entry valid flops.
`default_nettype none
module lfu_entry_store
   import lfu_pkg::*;
#(
   parameter int ENTRIES = 16,
   parameter int IW      = 4
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          rd_en,
   input  wire logic [IW-1:0] rd_addr,
   output      logic          rd_strobe_ff,
   output      logic [IW-1:0] rd_idx_ff,
   output      logic          rd_valid_ff,
   output      entry_type     rd_entry_ff,
   input  wire logic          wr_en,
   input  wire logic [IW-1:0] wr_addr,
   input  wire entry_type     wr_entry,
   input  wire logic          clr_en,
   input  wire logic [IW-1:0] clr_addr
);

   entry_type           mem [ENTRIES];
   logic [ENTRIES-1:0]  valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
      if (rd_en) begin
         rd_entry_ff <= mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
         rd_idx_ff   <= rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rd_strobe_ff <= 1'b0;
      end else begin
         rd_strobe_ff <= rd_en;
         // a slot both evicted and refilled stays valid
         if (clr_en && !(wr_en && (wr_addr == clr_addr))) begin
            valid_ff[clr_addr] <= 1'b0;
         end
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

endmodule
`default_nettype wire

>>> rtl/lfu_scan_unit.sv
// Shared match and victim compare unit, fed one entry per cycle during a scan.
`default_nettype none
module lfu_scan_unit
   import lfu_pkg::*;
#(
   parameter int IW = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic             strobe,
   input  wire logic [IW-1:0]    idx,
   input  wire logic             valid,
   input  wire entry_type        entry,
   input  wire logic [KEY_W-1:0] req_key,
   input  wire logic [TCH_W-1:0] touch_clock,
   output      scan_flags_type   flags_ff,
   output      logic [IW-1:0]    found_idx_ff,
   output      entry_type        found_entry_ff,
   output      logic [IW-1:0]    vic_idx_ff,
   output      logic [KEY_W-1:0] vic_key_ff,
   output      logic [IW-1:0]    free_idx_ff
);

   logic [CNT_W-1:0] vic_count_ff;
   logic [TCH_W-1:0] vic_age_ff;
   logic [TCH_W-1:0] age;
   logic             is_match;
   logic             is_victim;

   assign age      = touch_clock - entry.touch;
   assign is_match = valid && (entry.key == req_key);
   // strict compares keep the lowest index on a full tie
   assign is_victim = valid && (!flags_ff.victim || (entry.count < vic_count_ff) ||
                      ((entry.count == vic_count_ff) && (age > vic_age_ff)));

   always_ff @(posedge clock) begin
      if (reset || start) begin
         flags_ff <= '0;
      end else if (strobe) begin
         if (is_match && !flags_ff.found) begin
            flags_ff.found <= 1'b1;
         end
         if (is_victim) begin
            flags_ff.victim <= 1'b1;
         end
         if (!valid && !flags_ff.free) begin
            flags_ff.free <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (strobe) begin
         if (is_match && !flags_ff.found) begin
            found_idx_ff   <= idx;
            found_entry_ff <= entry;
         end
         if (is_victim) begin
            vic_idx_ff   <= idx;
            vic_key_ff   <= entry.key;
            vic_count_ff <= entry.count;
            vic_age_ff   <= age;
         end
         if (!valid && !flags_ff.free) begin
            free_idx_ff <= idx;
         end
      end
   end

endmodule
`default_nettype wire

>>> rtl/lfu_cache_engine_unit.sv
// LFU cache engine top level: stream channels, sequencer, write-back and result register.
//
// Fully associative key/value cache, least-frequently-used replacement, ties to the
// least recently touched entry. Input words on req_* carry a get or a put (req_tuser),
// result words on rsp_* carry hit/evicted flags plus the read value and evicted key.
// Configuration: csr_data writes the capacity; csr_ready is always high, write only
// while the engine is idle.
// From acceptance to rsp_tvalid the sequencer streams the entry memory through the
// shared compare unit (ST_SCAN), drains the read register (ST_DRAIN), writes back
// (ST_WRITE) and loads the result register (ST_DONE).
// The engine takes one word at a time: req_tready is high only while the
// sequencer is idle, and it returns to idle as the result enters the output register,
// so a waiting result does not hold off the next word.
// If the receiver stalls, a finished result waits in the sequencer until the output
// register is free; the output holds steady while rsp_tready is low.
// Reset: all entries invalid, occupancy and touch clock zero, capacity 16. No
// clearing pass is needed; the valid flops clear at once.
`default_nettype none
module lfu_cache_engine_unit
   import lfu_pkg::*;
#(
   parameter int ENTRIES = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // req_tdata: key [31:0], value [63:32]; req_tuser: cmd
   input  wire logic                   req_tvalid,
   output      logic                   req_tready,
   input  wire logic [KEY_W+VAL_W-1:0] req_tdata,
   input  wire logic                   req_tuser,
   // rsp_tdata: read_value [31:0], evicted_key [63:32]; rsp_tuser: hit [0], evicted [1]
   output      logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   output      logic [VAL_W+KEY_W-1:0] rsp_tdata,
   output      logic [1:0]             rsp_tuser,
   input  wire logic                   csr_valid,
   output      logic                   csr_ready,
   input  wire logic [CAP_W-1:0]       csr_data
);

   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int OW = $clog2(ENTRIES + 1);
   localparam int CW = (OW > CAP_W) ? OW : CAP_W;
   localparam logic [CW-1:0] ENT_C  = CW'(ENTRIES);
   localparam logic [IW-1:0] LAST_I = IW'(ENTRIES - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_WRITE,
      ST_DONE
   } state_type;

   state_type        state_ff;
   logic [IW-1:0]    ptr_ff;
   logic [CAP_W-1:0] cap_ff;
   logic [OW-1:0]    occ_ff;
   logic [OW-1:0]    occ_in;
   logic [TCH_W-1:0] tc_ff;
   logic             cmd_ff;
   logic [KEY_W-1:0] key_ff;
   logic [VAL_W-1:0] val_ff;
   logic             res_hit_ff;
   logic             res_ev_ff;
   logic [VAL_W-1:0] res_rd_ff;
   logic [KEY_W-1:0] res_evk_ff;
   logic             rsp_valid_ff;
   logic [1:0]       rsp_user_ff;
   logic [VAL_W+KEY_W-1:0] rsp_data_ff;

   logic             rd_strobe;
   logic [IW-1:0]    rd_idx;
   logic             rd_valid;
   entry_type        rd_entry;

   scan_flags_type   flags;
   logic [IW-1:0]    found_idx;
   entry_type        found_entry;
   logic [IW-1:0]    vic_idx;
   logic [KEY_W-1:0] vic_key;
   logic [IW-1:0]    free_idx;

   logic             accept;
   logic             start;
   logic             rd_en;
   logic [CW-1:0]    cap_eff;
   logic             is_put;
   logic             do_evict;
   logic             have_slot;
   logic [IW-1:0]    slot_idx;
   logic             wb_en;
   logic [IW-1:0]    wb_addr;
   entry_type        wb_entry;
   logic             clr_en;
   logic             out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign start      = accept;
   assign csr_ready  = 1'b1;
   assign rd_en      = (state_ff == ST_SCAN);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   lfu_entry_store #(
      .ENTRIES (ENTRIES),
      .IW      (IW)
   ) u_store (
      .clock        (clock),
      .reset        (reset),
      .rd_en        (rd_en),
      .rd_addr      (ptr_ff),
      .rd_strobe_ff (rd_strobe),
      .rd_idx_ff    (rd_idx),
      .rd_valid_ff  (rd_valid),
      .rd_entry_ff  (rd_entry),
      .wr_en        (wb_en),
      .wr_addr      (wb_addr),
      .wr_entry     (wb_entry),
      .clr_en       (clr_en),
      .clr_addr     (vic_idx)
   );

   lfu_scan_unit #(
      .IW (IW)
   ) u_scan (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .strobe         (rd_strobe),
      .idx            (rd_idx),
      .valid          (rd_valid),
      .entry          (rd_entry),
      .req_key        (key_ff),
      .touch_clock    (tc_ff),
      .flags_ff       (flags),
      .found_idx_ff   (found_idx),
      .found_entry_ff (found_entry),
      .vic_idx_ff     (vic_idx),
      .vic_key_ff     (vic_key),
      .free_idx_ff    (free_idx)
   );

   // write-back decisions, valid in ST_WRITE
   always_comb begin
      cap_eff   = (CW'(cap_ff) > ENT_C) ? ENT_C : CW'(cap_ff);
      is_put    = (cmd_ff == CMD_PUT) && (cap_eff != '0);
      do_evict  = is_put && !flags.found && flags.victim && (CW'(occ_ff) >= cap_eff);
      have_slot = flags.free || do_evict;
      // lowest invalid slot once the victim has been dropped
      if (flags.free && (!do_evict || (free_idx < vic_idx))) begin
         slot_idx = free_idx;
      end else begin
         slot_idx = vic_idx;
      end

      wb_en          = 1'b0;
      clr_en         = 1'b0;
      wb_addr        = found_idx;
      wb_entry.key   = key_ff;
      wb_entry.value = found_entry.value;
      wb_entry.count = (found_entry.count == '1) ? found_entry.count
                                                 : found_entry.count + CNT_W'(1);
      wb_entry.touch = tc_ff + TCH_W'(1);
      occ_in         = occ_ff;

      if (state_ff == ST_WRITE) begin
         if (flags.found) begin
            if ((cmd_ff == CMD_GET) || is_put) begin
               wb_en = 1'b1;
            end
            if (is_put) begin
               wb_entry.value = val_ff;
            end
         end else if (is_put && have_slot) begin
            wb_en          = 1'b1;
            clr_en         = do_evict;
            wb_addr        = slot_idx;
            wb_entry.value = val_ff;
            wb_entry.count = CNT_W'(1);
            occ_in         = occ_ff + OW'(1) - (do_evict ? OW'(1) : OW'(0));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ptr_ff       <= '0;
         cap_ff       <= CAP_RESET;
         occ_ff       <= '0;
         tc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            cap_ff <= csr_data;
         end
         if ((state_ff == ST_DONE) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         occ_ff <= occ_in;
         if (wb_en) begin
            tc_ff <= tc_ff + TCH_W'(1);
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  ptr_ff   <= '0;
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               ptr_ff <= ptr_ff + IW'(1);
               if (ptr_ff == LAST_I) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               state_ff <= ST_WRITE;
            end
            ST_WRITE: begin
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_tuser;
         key_ff <= req_tdata[KEY_W-1:0];
         val_ff <= req_tdata[KEY_W+VAL_W-1:KEY_W];
      end
      if (state_ff == ST_WRITE) begin
         res_hit_ff <= flags.found;
         res_rd_ff  <= (flags.found && (cmd_ff == CMD_GET)) ? found_entry.value : '0;
         res_ev_ff  <= do_evict;
         res_evk_ff <= do_evict ? vic_key : '0;
      end
      if ((state_ff == ST_DONE) && out_free) begin
         rsp_data_ff <= {res_evk_ff, res_rd_ff};
         rsp_user_ff <= {res_ev_ff, res_hit_ff};
      end
   end

endmodule
`default_nettype wire

>>> rtl/lfu_checker.sv
// Port-level checks for the LFU cache engine, bound to the top level.
`default_nettype none
module lfu_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [63:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result word changed while stalled");

   // the engine is busy after taking a word
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken twice in a row");

   // an eviction only happens on a miss
   a_evict_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> !rsp_tuser[0])
      else $error("eviction reported on a hit");

   a_evk_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[1] |-> rsp_tdata[63:32] == 32'd0)
      else $error("evicted key not zero without eviction");

   a_rd_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[31:0] == 32'd0)
      else $error("read value not zero on a miss");

endmodule

bind lfu_cache_engine_unit lfu_checker u_lfu_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking testbench for the LFU cache engine: stream driver, result monitor, predictor.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import lfu_pkg::*;

   localparam int SLOTS = 16;

   typedef struct packed {
      cmd_type          cmd;
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value;
   } access_type;

   typedef struct packed {
      logic             hit;
      logic [VAL_W-1:0] read_value;
      logic             evicted;
      logic [KEY_W-1:0] evicted_key;
   } outcome_type;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [KEY_W+VAL_W-1:0] req_tdata = '0;
   logic                   req_tuser = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [VAL_W+KEY_W-1:0] rsp_tdata;
   logic [1:0]             rsp_tuser;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CAP_W-1:0]       csr_data = '0;

   // predictor state
   logic [CAP_W-1:0] capacity_reg = CAP_RESET;
   logic             slot_valid [SLOTS] = '{default: 1'b0};
   logic [KEY_W-1:0] slot_key   [SLOTS] = '{default: '0};
   logic [VAL_W-1:0] slot_value [SLOTS] = '{default: '0};
   logic [CNT_W-1:0] slot_count [SLOTS] = '{default: '0};
   logic [TCH_W-1:0] slot_touch [SLOTS] = '{default: '0};
   int               occupancy = 0;
   logic [TCH_W-1:0] touch_clock = '0;

   access_type  access_queue[$];
   outcome_type expected_outcomes[$];
   access_type  drv_item;

   int send_idle_pct = 15;
   int recv_idle_pct = 59;
   int mismatch_count = 0;
   int result_count = 0;
   int hit_count = 0;
   int evict_count = 0;
   int cap_writes = 0;

   lfu_cache_engine_unit #(.ENTRIES(SLOTS)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // key [31:0], value [63:32]
      .req_tuser  (req_tuser),   // cmd
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // read_value [31:0], evicted_key [63:32]
      .rsp_tuser  (rsp_tuser),   // hit [0], evicted [1]
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic void bump_slot(input int s);
      if (slot_count[s] != '1)
         slot_count[s] = slot_count[s] + 1'b1;
      touch_clock = touch_clock + 1'b1;
      slot_touch[s] = touch_clock;
   endfunction

   // applies one get/put to the shadow cache and returns the result word it should produce
   function automatic outcome_type apply_access(input access_type acc);
      outcome_type res;
      int i, found, victim, slot, limit;
      logic [TCH_W-1:0] age_i, age_v;
      res = '0;
      found = -1;
      victim = -1;
      slot = -1;
      limit = (capacity_reg > SLOTS) ? SLOTS : int'(capacity_reg);
      for (i = 0; i < SLOTS; i++)
         if (found < 0 && slot_valid[i] && slot_key[i] == acc.key)
            found = i;
      res.hit = (found >= 0);
      if (acc.cmd == CMD_GET) begin
         if (found >= 0) begin
            res.read_value = slot_value[found];
            bump_slot(found);
         end
      end else if (limit != 0) begin
         if (found >= 0) begin
            slot_value[found] = acc.value;
            bump_slot(found);
         end else begin
            if (occupancy >= limit) begin
               // lowest count wins, then the oldest touch, then the lowest slot
               for (i = 0; i < SLOTS; i++) begin
                  if (slot_valid[i]) begin
                     if (victim < 0) begin
                        victim = i;
                     end else begin
                        age_i = touch_clock - slot_touch[i];
                        age_v = touch_clock - slot_touch[victim];
                        if (slot_count[i] < slot_count[victim] ||
                            (slot_count[i] == slot_count[victim] && age_i > age_v))
                           victim = i;
                     end
                  end
               end
               if (victim >= 0) begin
                  slot_valid[victim] = 1'b0;
                  res.evicted = 1'b1;
                  res.evicted_key = slot_key[victim];
                  if (occupancy > 0)
                     occupancy--;
               end
            end
            for (i = 0; i < SLOTS; i++)
               if (slot < 0 && !slot_valid[i])
                  slot = i;
            if (slot >= 0) begin
               slot_valid[slot] = 1'b1;
               slot_key[slot] = acc.key;
               slot_value[slot] = acc.value;
               slot_count[slot] = 1;
               touch_clock = touch_clock + 1'b1;
               slot_touch[slot] = touch_clock;
               occupancy++;
            end
         end
      end
      return res;
   endfunction

   // request driver
   always @(posedge clock) begin : feed
      logic take;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         take = !req_tvalid;
         if (req_tvalid && req_tready) begin
            expected_outcomes.push_back(apply_access(drv_item));
            take = 1'b1;
         end
         if (take) begin
            if (access_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               drv_item = access_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {drv_item.value, drv_item.key};
               req_tuser  <= drv_item.cmd;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin : watch
      outcome_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.hit         = rsp_tuser[0];
            got.evicted     = rsp_tuser[1];
            got.read_value  = rsp_tdata[VAL_W-1:0];
            got.evicted_key = rsp_tdata[VAL_W+KEY_W-1:VAL_W];
            result_count++;
            hit_count += got.hit;
            evict_count += got.evicted;
            if (expected_outcomes.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected result word hit=%0b value=%h evicted=%0b key=%h",
                        $time, got.hit, got.read_value, got.evicted, got.evicted_key);
            end else begin
               want = expected_outcomes.pop_front();
               if (got !== want) begin
                  mismatch_count++;
                  $display({"%0t: word %0d expected hit=%0b value=%h evicted=%0b key=%h,",
                            " got hit=%0b value=%h evicted=%0b key=%h"},
                           $time, result_count, want.hit, want.read_value, want.evicted,
                           want.evicted_key, got.hit, got.read_value, got.evicted,
                           got.evicted_key);
               end
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   function automatic void queue_access(input cmd_type c, input logic [KEY_W-1:0] k,
                                        input logic [VAL_W-1:0] v);
      access_queue.push_back('{cmd: c, key: k, value: v});
   endfunction

   // polled on the falling edge so that all edge updates have settled
   task automatic drain();
      do @(negedge clock);
      while (access_queue.size() != 0 || req_tvalid || expected_outcomes.size() != 0);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] cap);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= cap;
      do @(posedge clock);
      while (!csr_ready);
      capacity_reg = cap;
      cap_writes++;
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   initial begin : stimulus
      logic [CAP_W-1:0] phase_caps [8] = '{5'd16, 5'd1, 5'd7, 5'd0, 5'd31, 5'd3, 5'd12, 5'd16};
      logic [KEY_W-1:0] key_pool[$];
      logic [KEY_W-1:0] k;
      int p, n, pool_size;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset capacity: empty miss, extreme keys and values, hits, updates
      queue_access(CMD_GET, 32'h0000_0000, 32'h1111_1111);
      queue_access(CMD_PUT, 32'h8000_0000, 32'h7fff_ffff);
      queue_access(CMD_PUT, 32'h7fff_ffff, 32'h8000_0000);
      queue_access(CMD_PUT, 32'h0000_0000, 32'h0000_0000);
      queue_access(CMD_PUT, 32'hffff_ffff, 32'hffff_ffff);
      queue_access(CMD_GET, 32'h8000_0000, 32'h0000_0000);
      queue_access(CMD_GET, 32'h7fff_ffff, 32'hffff_ffff);
      queue_access(CMD_PUT, 32'h0000_0000, 32'h5a5a_a5a5);
      queue_access(CMD_GET, 32'h0000_0000, 32'h0000_0000);
      queue_access(CMD_GET, 32'h0000_0001, 32'h0000_0000);
      queue_access(CMD_PUT, 32'hffff_ffff, 32'h0000_0001);
      drain();

      // capacity below occupancy: each put miss evicts one, ties go to the oldest
      write_capacity(5'd2);
      queue_access(CMD_PUT, 32'h1234_5678, $urandom);
      queue_access(CMD_PUT, 32'h1234_5679, $urandom);
      queue_access(CMD_GET, 32'h1234_5679, $urandom);
      queue_access(CMD_PUT, 32'hdead_beef, $urandom);
      drain();

      // zero capacity: puts change nothing but still report presence
      write_capacity(5'd0);
      queue_access(CMD_PUT, 32'h0bad_f00d, $urandom);
      queue_access(CMD_PUT, 32'h0000_0000, 32'h0000_002a);
      queue_access(CMD_GET, 32'h0000_0000, $urandom);
      queue_access(CMD_GET, 32'h0bad_f00d, $urandom);
      drain();

      // capacity above the entry count behaves as full size
      write_capacity(5'd31);
      for (n = 0; n < 5; n++)
         queue_access(CMD_PUT, $urandom, $urandom);
      queue_access(CMD_GET, 32'h7fff_ffff, $urandom);
      drain();

      for (p = 0; p < 8; p++) begin
         if (p == 3) begin
            send_idle_pct = 59;
            recv_idle_pct = 15;
         end else if (p == 6) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         write_capacity(phase_caps[p]);
         // five more keys than the capped capacity, so both hits and evictions are common
         pool_size = ((phase_caps[p] > SLOTS) ? SLOTS : int'(phase_caps[p])) + 5;
         key_pool.delete();
         for (n = 0; n < pool_size; n++) begin
            case ($urandom_range(0, 11))
               0:       k = 32'h0000_0000;
               1:       k = 32'h8000_0000;
               2:       k = 32'h7fff_ffff;
               3:       k = 32'hffff_ffff;
               default: k = $urandom;
            endcase
            key_pool.push_back(k);
         end
         for (n = 0; n < 56; n++) begin
            if ($urandom_range(0, 9) == 0)
               k = $urandom;
            else
               k = key_pool[$urandom_range(0, pool_size - 1)];
            queue_access(cmd_type'($urandom_range(0, 1)), k, $urandom);
         end
         drain();
      end

      repeat (24) @(posedge clock);
      $display("%0d words checked: %0d hits, %0d evictions, %0d capacity writes",
               result_count, hit_count, evict_count, cap_writes);
      $display("idling covered sender-heavy, receiver-heavy and back-to-back traffic");
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("timeout with %0d words outstanding", expected_outcomes.size());
      $display("end of test: mismatches");
      $finish;
   end

endmodule
